@@ src/tcd_pkg.sv @@
// Shared types and immediate-decode helpers for the Thumb instruction class decoder.
package tcd_pkg;

  localparam int unsigned HalfW = 16;
  localparam int unsigned ImmW  = 32;

  typedef enum logic [3:0] {
    CLS_NONE    = 4'd0,
    CLS_BL      = 4'd1,
    CLS_BCOND   = 4'd2,
    CLS_B       = 4'd3,
    CLS_LDRLIT  = 4'd4,
    CLS_LDRIMM  = 4'd5,
    CLS_LDRBIMM = 4'd6,
    CLS_LDRREG  = 4'd7,
    CLS_ADD     = 4'd8,
    CLS_MOVT    = 4'd9,
    CLS_MOV     = 4'd10,
    CLS_CMP     = 4'd11,
    CLS_AND     = 4'd12,
    CLS_PUSH    = 4'd13,
    CLS_STR     = 4'd14
  } insn_class_e;

  typedef struct packed {
    insn_class_e       cls;
    logic              wide;
    logic [3:0]        rd;
    logic [3:0]        rn;
    logic [3:0]        rm;
    logic [ImmW-1:0]   imm;
    logic [HalfW-1:0]  list;
    logic              frame;
    logic [1:0]        sh;
    logic              post;
    logic              wb;
  } decode_t;

  // i:imm3:imm8 from the two halfwords of a wide data-processing encoding
  function automatic logic [11:0] wide_imm12(input logic [HalfW-1:0] a,
                                             input logic [HalfW-1:0] b);
    return {a[10], b[14:12], b[7:0]};
  endfunction

  function automatic logic [15:0] wide_imm16(input logic [HalfW-1:0] a,
                                             input logic [HalfW-1:0] b);
    return {a[3:0], wide_imm12(a, b)};
  endfunction

  // Thumb-2 modified immediate: byte replication or rotated 1:imm7
  function automatic logic [ImmW-1:0] expand_mod_imm(input logic [11:0] imm12);
    logic [7:0]        by;
    logic [ImmW-1:0]   rv;
    logic [2*ImmW-1:0] dbl;
    by  = imm12[7:0];
    rv  = {24'd0, 1'b1, imm12[6:0]};
    dbl = {rv, rv} >> imm12[11:7];
    if (imm12[11:10] == 2'b00) begin
      case (imm12[9:8])
        2'd0:    return {24'd0, by};
        2'd1:    return {8'd0, by, 8'd0, by};
        2'd2:    return {by, 8'd0, by, 8'd0};
        default: return {by, by, by, by};
      endcase
    end
    return dbl[ImmW-1:0];
  endfunction

  // BL/BLX offset: sign-extended S:I1:I2:imm10:imm11:0
  function automatic logic [ImmW-1:0] bl_imm(input logic [HalfW-1:0] a,
                                             input logic [HalfW-1:0] b);
    logic s, i1, i2;
    s  = a[10];
    i1 = ~(b[13] ^ s);
    i2 = ~(b[11] ^ s);
    return {{8{s}}, i1, i2, a[9:0], b[10:0], 1'b0};
  endfunction

endpackage

@@ src/thumb_instruction_class_decoder.sv @@
// Thumb/Thumb-2 instruction class decoder: input register, decode, result register.
//
// Takes one instruction word per cycle (first and second halfword) while in_stall_o
// is low and returns its width, class and decoded operand fields. Throughput is one
// word per clock while in_stall_o is low. An accepted word waits in the input
// register; a single combinational decode pass then loads its decoded fields into
// the result register, which drives the outputs. The two register stages advance
// independently: while a finished result waits under out_stall_i the input register
// still takes one more word, and in_stall_o rises only once both stages are full and
// the output is stalled. Fields a class does not define read 0.
module thumb_instruction_class_decoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [tcd_pkg::HalfW-1:0]  first_half_i,
  input  logic [tcd_pkg::HalfW-1:0]  second_half_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [3:0]                 insn_class_o,
  output logic                       is_wide_o,
  output logic [3:0]                 dest_reg_o,
  output logic [3:0]                 base_reg_o,
  output logic [3:0]                 index_reg_o,
  output logic [tcd_pkg::ImmW-1:0]   immediate_o,
  output logic [tcd_pkg::HalfW-1:0]  reg_list_o,
  output logic                       frame_push_o,
  output logic [1:0]                 shift_amount_o,
  output logic                       post_indexed_o,
  output logic                       writeback_o
);
  import tcd_pkg::*;

  logic             s1_valid_q, s1_valid_d;
  logic [HalfW-1:0] a_q, b_q;
  logic             s2_valid_q, s2_valid_d;
  decode_t          res_q, dec;
  logic             s2_load, s1_load;

  assign s2_load    = s1_valid_q && (!s2_valid_q || !out_stall_i);
  assign s1_load    = in_valid_i && !in_stall_o;
  assign in_stall_o = s1_valid_q && s2_valid_q && out_stall_i;

  assign s1_valid_d = s1_load || (s1_valid_q && !s2_load);
  assign s2_valid_d = s2_load || (s2_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      a_q <= first_half_i;
      b_q <= second_half_i;
    end
    if (s2_load) begin
      res_q <= dec;
    end
  end

  // priority decode: first matching class wins
  always_comb begin
    logic [HalfW-1:0] a, b;
    a = a_q;
    b = b_q;
    dec      = '0;
    dec.cls  = CLS_NONE;
    dec.wide = (a[15:13] == 3'b111) && (a[12:11] != 2'b00);

    if ((a & 16'hF800) == 16'hF000 &&
        ((b & 16'hD000) == 16'hD000 || (b & 16'hD001) == 16'hC000)) begin
      dec.cls = CLS_BL;
      dec.imm = bl_imm(a, b);
    end else if (a[15:12] == 4'hD && a[11:8] != 4'hF && a[11:8] != 4'hE) begin
      dec.cls = CLS_BCOND;
    end else if ((a & 16'hF800) == 16'hE000 ||
                 ((a & 16'hF800) == 16'hF000 && (b & 16'hD000) == 16'h9000)) begin
      dec.cls = CLS_B;
    end else if ((a & 16'hF800) == 16'h4800) begin
      dec.cls = CLS_LDRLIT;
      dec.rd  = {1'b0, a[10:8]};
      dec.rn  = 4'd15;
      dec.imm = {22'd0, a[7:0], 2'b00};
    end else if ((a & 16'hFF7F) == 16'hF85F) begin
      dec.cls = CLS_LDRLIT;
      dec.rd  = b[15:12];
      dec.rn  = 4'd15;
      // U clear: subtract offset
      dec.imm = a[7] ? {20'd0, b[11:0]} : (ImmW'(0) - {20'd0, b[11:0]});
    end else if ((a & 16'hF800) == 16'h6800) begin
      dec.cls = CLS_LDRIMM;
      dec.rd  = {1'b0, a[2:0]};
      dec.rn  = {1'b0, a[5:3]};
      dec.imm = {25'd0, a[10:6], 2'b00};
    end else if ((a & 16'hF800) == 16'h7800) begin
      dec.cls = CLS_LDRBIMM;
      dec.rd  = {1'b0, a[2:0]};
      dec.rn  = {1'b0, a[5:3]};
      dec.imm = {27'd0, a[10:6]};
    end else if ((a & 16'hFE00) == 16'h5800) begin
      dec.cls = CLS_LDRREG;
      dec.rd  = {1'b0, a[2:0]};
      dec.rn  = {1'b0, a[5:3]};
      dec.rm  = {1'b0, a[8:6]};
    end else if ((a & 16'hFFF0) == 16'hF850 && (b & 16'h0FC0) == 16'h0000) begin
      dec.cls = CLS_LDRREG;
      dec.rd  = b[15:12];
      dec.rn  = a[3:0];
      dec.rm  = b[3:0];
      dec.sh  = b[5:4];
    end else if ((a & 16'hFE00) == 16'h1800) begin
      dec.cls = CLS_ADD;
      dec.rd  = {1'b0, a[2:0]};
      dec.rn  = {1'b0, a[5:3]};
      dec.rm  = {1'b0, a[8:6]};
    end else if ((a & 16'hFF00) == 16'h4400) begin
      dec.cls = CLS_ADD;
      dec.rd  = {a[7], a[2:0]};
      dec.rn  = {a[7], a[2:0]};
      dec.rm  = a[6:3];
    end else if ((a & 16'hFFE0) == 16'hEB00) begin
      dec.cls = CLS_ADD;
      dec.rd  = b[11:8];
      dec.rn  = a[3:0];
      dec.rm  = b[3:0];
    end else if ((a & 16'hFBF0) == 16'hF2C0 && !b[15]) begin
      dec.cls = CLS_MOVT;
      dec.rd  = b[11:8];
      dec.imm = {16'd0, wide_imm16(a, b)};
    end else if ((a & 16'hF800) == 16'h2000) begin
      dec.cls = CLS_MOV;
      dec.rd  = {1'b0, a[10:8]};
      dec.imm = {24'd0, a[7:0]};
    end else if ((a & 16'hFBEF) == 16'hF04F && !b[15]) begin
      dec.cls = CLS_MOV;
      dec.rd  = b[11:8];
      dec.imm = expand_mod_imm(wide_imm12(a, b));
    end else if ((a & 16'hFBF0) == 16'hF240 && !b[15]) begin
      dec.cls = CLS_MOV;
      dec.rd  = b[11:8];
      dec.imm = {16'd0, wide_imm16(a, b)};
    end else if ((a & 16'hF800) == 16'h2800) begin
      dec.cls = CLS_CMP;
      dec.rn  = {1'b0, a[10:8]};
      dec.imm = {24'd0, a[7:0]};
    end else if ((a & 16'hFBF0) == 16'hF1B0 && (b & 16'h8F00) == 16'h0F00) begin
      dec.cls = CLS_CMP;
      dec.rn  = a[3:0];
      dec.imm = expand_mod_imm(wide_imm12(a, b));
    end else if ((a & 16'hFBE0) == 16'hF000 && !b[15]) begin
      dec.cls = CLS_AND;
      dec.rn  = a[3:0];
      dec.rd  = b[11:8];
      dec.imm = expand_mod_imm(wide_imm12(a, b));
    end else if ((a & 16'hFE00) == 16'hB400) begin
      dec.cls  = CLS_PUSH;
      dec.rn   = 4'd13;
      dec.list = {1'b0, a[8], 6'd0, a[7:0]};
    end else if (a == 16'hE92D) begin
      dec.cls  = CLS_PUSH;
      dec.rn   = 4'd13;
      dec.list = b;
    end else if (a == 16'hF84D && (b & 16'h0FFF) == 16'h0D04) begin
      // single-register push is STR Rt, [SP, #-4]!
      dec.cls  = CLS_PUSH;
      dec.rn   = 4'd13;
      dec.list = HalfW'(1) << b[15:12];
    end else if ((a & 16'hF800) == 16'h6000) begin
      dec.cls  = CLS_STR;
      dec.rd   = {1'b0, a[2:0]};
      dec.rn   = {1'b0, a[5:3]};
      dec.imm  = {25'd0, a[10:6], 2'b00};
      dec.post = 1'b1;
    end else if ((a & 16'hF800) == 16'h9000) begin
      dec.cls  = CLS_STR;
      dec.rd   = {1'b0, a[10:8]};
      dec.rn   = 4'd13;
      dec.imm  = {22'd0, a[7:0], 2'b00};
      dec.post = 1'b1;
    end else if ((a & 16'hFFF0) == 16'hF8C0) begin
      dec.cls  = CLS_STR;
      dec.rd   = b[15:12];
      dec.rn   = a[3:0];
      dec.imm  = {20'd0, b[11:0]};
      dec.post = 1'b1;
    end else if ((a & 16'hFFF0) == 16'hF840 && b[11]) begin
      dec.cls  = CLS_STR;
      dec.rd   = b[15:12];
      dec.rn   = a[3:0];
      dec.imm  = {24'd0, b[7:0]};
      dec.post = b[10];
      dec.wb   = b[8];
    end

    dec.frame = (dec.cls == CLS_PUSH) && dec.list[14];
  end

  assign out_valid_o    = s2_valid_q;
  assign insn_class_o   = res_q.cls;
  assign is_wide_o      = res_q.wide;
  assign dest_reg_o     = res_q.rd;
  assign base_reg_o     = res_q.rn;
  assign index_reg_o    = res_q.rm;
  assign immediate_o    = res_q.imm;
  assign reg_list_o     = res_q.list;
  assign frame_push_o   = res_q.frame;
  assign shift_amount_o = res_q.sh;
  assign post_indexed_o = res_q.post;
  assign writeback_o    = res_q.wb;

  // a word taken into an empty pipe passes the input register, then the result register, before out_valid_o rises
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !s1_valid_q && !s2_valid_q) |=> ##1 out_valid_o)
    else $error("accepted word did not reach the output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && insn_class_o == CLS_NONE) |->
      (immediate_o == '0 && reg_list_o == '0 && dest_reg_o == '0 && base_reg_o == '0))
    else $error("unmatched word carries operand fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (frame_push_o || reg_list_o != '0)) |-> (insn_class_o == CLS_PUSH))
    else $error("register list outside push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (writeback_o || post_indexed_o)) |-> (insn_class_o == CLS_STR))
    else $error("store flags outside str");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && shift_amount_o != 2'd0) |-> (insn_class_o == CLS_LDRREG && is_wide_o))
    else $error("shift amount outside wide ldr register");

endmodule
